// ===== rtl/pfl_pkg.sv =====
// Phong fragment lighting: shared constants and widths.
// No dependencies; imported by the interfaces and the core.
`default_nettype none
package pfl_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NRM_W     = 16;
  localparam int GAIN_W    = 17;
  localparam int SHIN_W    = 8;
  localparam int OUT_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int SQR_W  = 2 * NRM_W - 1;
  localparam int L2_W   = SQR_W + 1;
  localparam int RAD_W  = L2_W + 16;
  localparam int LEN_W  = RAD_W / 2;
  localparam int P_W    = NRM_W + 3;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int PRE_SH = FRAC_BITS + 8 - DIV_STEPS;
  localparam int D1_W   = LEN_W + 2;
  localparam int REM_W  = D1_W + 1;
  localparam int PROD_W = 2 * Q_W;
  localparam int T_W    = Q_W + 2;
  localparam int SUM_W  = GAIN_W + 2;

  localparam logic [Q_W-1:0] ONE_Q   = Q_W'(1) << FRAC_BITS;
  localparam logic [Q_W-1:0] THIRD_Q = Q_W'(((1 << FRAC_BITS) + 1) / 3);

  localparam logic [GAIN_W-1:0] KA_RST = GAIN_W'(13107);
  localparam logic [GAIN_W-1:0] KD_RST = GAIN_W'(39322);
  localparam logic [GAIN_W-1:0] KS_RST = GAIN_W'(65536);
  localparam logic [SHIN_W-1:0] SH_RST = SHIN_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMBIENT  = 2'd0,
    REG_DIFFUSE  = 2'd1,
    REG_SPECULAR = 2'd2,
    REG_SHINE    = 2'd3
  } cfg_reg_t;

endpackage
`default_nettype wire

// ===== rtl/pfl_in_if.sv =====
// Input channel: valid/ready with the eye-space normal.
// Depends on pfl_pkg.
`default_nettype none
interface pfl_in_if;
  import pfl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  modport source (output valid, normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/pfl_out_if.sv =====
// Result channel: valid/ready with the gray intensity.
// Depends on pfl_pkg.
`default_nettype none
interface pfl_out_if;
  import pfl_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] intensity;
  modport source (output valid, intensity, input ready);
  modport sink   (input valid, intensity, output ready);
endinterface
`default_nettype wire

// ===== rtl/phong_fragment_lighting_core.sv =====
// Phong ambient/diffuse/specular shading core, fully pipelined.
// Depends on pfl_pkg, pfl_in_if, pfl_out_if.
//
//  channel   dir  payload                          handshake
//  in_ch     in   normal_x/y/z (s16 Q2.14)         valid/ready
//  out_ch    out  intensity (u16 Q0.16)            valid/ready
//  cfg       in   cfg_index, cfg_data (17b)        cfg_we
//
// One fragment per cycle unless out_ch stalls; stages: squares, 25 sqrt stages,
// 18 divider stages (two dividers side by side), 2 reflection stages, 9 power
// stages by squaring, gain multiply and the output register.
// Synchronous active-low reset clears valids and reloads register defaults.
// A stall freezes every stage at once; in_ch.ready follows the output slot.
`default_nettype none
module phong_fragment_lighting_core (
  input  wire                          clk,
  input  wire                          rst_n,
  pfl_in_if.sink                       in_ch,
  pfl_out_if.source                    out_ch,
  input  wire                          cfg_we,
  input  wire [pfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [pfl_pkg::GAIN_W-1:0]    cfg_data
);
  import pfl_pkg::*;

  localparam int SQ_N  = LEN_W;
  localparam int DV_N  = DIV_STEPS;
  localparam int PW_N  = SHIN_W;
  localparam int NST   = 1 + (SQ_N + 1) + (DV_N + 1) + 2 + (PW_N + 1) + 1 + 1;

  logic [GAIN_W-1:0] ka_r, kd_r, ks_r;
  logic [SHIN_W-1:0] shin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ka_r   <= KA_RST;
      kd_r   <= KD_RST;
      ks_r   <= KS_RST;
      shin_r <= SH_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AMBIENT:  ka_r   <= cfg_data;
        REG_DIFFUSE:  kd_r   <= cfg_data;
        REG_SPECULAR: ks_r   <= cfg_data;
        REG_SHINE:    shin_r <= cfg_data[SHIN_W-1:0];
        default:      ;
      endcase
    end
  end

  logic en;
  logic vld_r [0:NST-1];

  assign en           = !vld_r[NST-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < NST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // squares and light dot product
  logic [SQR_W-1:0]        a_sqx_r, a_sqy_r, a_sqz_r;
  logic signed [P_W-1:0]   a_p_r;
  logic signed [NRM_W-1:0] a_nz_r;
  logic signed [2*NRM_W-1:0] mx, my, mz;
  logic signed [P_W-1:0]   p_nxt;

  always_comb begin
    mx = in_ch.normal_x * in_ch.normal_x;
    my = in_ch.normal_y * in_ch.normal_y;
    mz = in_ch.normal_z * in_ch.normal_z;
    p_nxt = -(P_W'(in_ch.normal_x) <<< 1) + (P_W'(in_ch.normal_y) <<< 1)
            + P_W'(in_ch.normal_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sqx_r <= mx[SQR_W-1:0];
      a_sqy_r <= my[SQR_W-1:0];
      a_sqz_r <= mz[SQR_W-1:0];
      a_p_r   <= p_nxt;
      a_nz_r  <= in_ch.normal_z;
    end
  end

  // square root, one result bit per stage
  logic [RAD_W-1:0]        sq_v_r   [0:SQ_N];
  logic [RAD_W-1:0]        sq_res_r [0:SQ_N];
  logic signed [P_W-1:0]   sq_p_r   [0:SQ_N];
  logic signed [NRM_W-1:0] sq_nz_r  [0:SQ_N];
  logic [RAD_W-1:0]        sq_v_nxt   [1:SQ_N];
  logic [RAD_W-1:0]        sq_res_nxt [1:SQ_N];
  logic [L2_W-1:0]         l2;

  always_comb begin
    logic [RAD_W:0] tr;
    logic [RAD_W:0] bitv;
    l2 = L2_W'(a_sqx_r) + L2_W'(a_sqy_r) + L2_W'(a_sqz_r);
    for (int k = 0; k < SQ_N; k++) begin
      bitv = (RAD_W+1)'(1) << (RAD_W - 2 - 2 * k);
      tr   = {1'b0, sq_res_r[k]} + bitv;
      if ({1'b0, sq_v_r[k]} >= tr) begin
        sq_v_nxt[k+1]   = sq_v_r[k] - tr[RAD_W-1:0];
        sq_res_nxt[k+1] = (sq_res_r[k] >> 1) + bitv[RAD_W-1:0];
      end else begin
        sq_v_nxt[k+1]   = sq_v_r[k];
        sq_res_nxt[k+1] = sq_res_r[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_v_r[0]   <= {l2, 16'd0};
      sq_res_r[0] <= '0;
      sq_p_r[0]   <= a_p_r;
      sq_nz_r[0]  <= a_nz_r;
      for (int k = 1; k <= SQ_N; k++) begin
        sq_v_r[k]   <= sq_v_nxt[k];
        sq_res_r[k] <= sq_res_nxt[k];
        sq_p_r[k]   <= sq_p_r[k-1];
        sq_nz_r[k]  <= sq_nz_r[k-1];
      end
    end
  end

  // two restoring dividers: P/(3*len) and nz/len
  logic [REM_W-1:0] dv_rem1_r [0:DV_N];
  logic [REM_W-1:0] dv_rem2_r [0:DV_N];
  logic [Q_W-1:0]   dv_q1_r   [0:DV_N];
  logic [Q_W-1:0]   dv_q2_r   [0:DV_N];
  logic [D1_W-1:0]  dv_d1_r   [0:DV_N];
  logic [LEN_W-1:0] dv_d2_r   [0:DV_N];
  logic             dv_ov1_r  [0:DV_N];
  logic             dv_ov2_r  [0:DV_N];
  logic             dv_act_r  [0:DV_N];
  logic             dv_zp_r   [0:DV_N];
  logic [REM_W-1:0] dv_rem1_nxt [1:DV_N];
  logic [REM_W-1:0] dv_rem2_nxt [1:DV_N];
  logic [Q_W-1:0]   dv_q1_nxt   [1:DV_N];
  logic [Q_W-1:0]   dv_q2_nxt   [1:DV_N];

  logic [LEN_W-1:0] lens;
  logic [D1_W-1:0]  d1_init;
  logic [REM_W-1:0] r1_init, r2_init;

  always_comb begin
    logic [REM_W-1:0] rs1, rs2;
    lens    = sq_res_r[SQ_N][LEN_W-1:0];
    d1_init = D1_W'(lens) + (D1_W'(lens) << 1);
    r1_init = REM_W'(sq_p_r[SQ_N][P_W-2:0]) << PRE_SH;
    r2_init = REM_W'(sq_nz_r[SQ_N][NRM_W-2:0]) << PRE_SH;
    for (int k = 0; k < DV_N; k++) begin
      rs1 = dv_rem1_r[k] << 1;
      rs2 = dv_rem2_r[k] << 1;
      if (rs1 >= REM_W'(dv_d1_r[k])) begin
        dv_rem1_nxt[k+1] = rs1 - REM_W'(dv_d1_r[k]);
        dv_q1_nxt[k+1]   = {dv_q1_r[k][Q_W-2:0], 1'b1};
      end else begin
        dv_rem1_nxt[k+1] = rs1;
        dv_q1_nxt[k+1]   = {dv_q1_r[k][Q_W-2:0], 1'b0};
      end
      if (rs2 >= REM_W'(dv_d2_r[k])) begin
        dv_rem2_nxt[k+1] = rs2 - REM_W'(dv_d2_r[k]);
        dv_q2_nxt[k+1]   = {dv_q2_r[k][Q_W-2:0], 1'b1};
      end else begin
        dv_rem2_nxt[k+1] = rs2;
        dv_q2_nxt[k+1]   = {dv_q2_r[k][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem1_r[0] <= r1_init;
      dv_rem2_r[0] <= r2_init;
      dv_q1_r[0]   <= '0;
      dv_q2_r[0]   <= '0;
      dv_d1_r[0]   <= d1_init;
      dv_d2_r[0]   <= lens;
      dv_ov1_r[0]  <= r1_init >= REM_W'(d1_init);
      dv_ov2_r[0]  <= r2_init >= REM_W'(lens);
      dv_act_r[0]  <= (lens != '0) && (sq_p_r[SQ_N] > 0);
      dv_zp_r[0]   <= sq_nz_r[SQ_N] > 0;
      for (int k = 1; k <= DV_N; k++) begin
        dv_rem1_r[k] <= dv_rem1_nxt[k];
        dv_rem2_r[k] <= dv_rem2_nxt[k];
        dv_q1_r[k]   <= dv_q1_nxt[k];
        dv_q2_r[k]   <= dv_q2_nxt[k];
        dv_d1_r[k]   <= dv_d1_r[k-1];
        dv_d2_r[k]   <= dv_d2_r[k-1];
        dv_ov1_r[k]  <= dv_ov1_r[k-1];
        dv_ov2_r[k]  <= dv_ov2_r[k-1];
        dv_act_r[k]  <= dv_act_r[k-1];
        dv_zp_r[k]   <= dv_zp_r[k-1];
      end
    end
  end

  // reflection z term
  logic [Q_W-1:0]    dq, zq;
  logic [PROD_W-1:0] t_prod_r;
  logic [Q_W-1:0]    t_dq_r;
  logic              t_act_r;

  always_comb begin
    if (dv_ov1_r[DV_N] || dv_q1_r[DV_N] > ONE_Q) dq = ONE_Q;
    else                                         dq = dv_q1_r[DV_N];
    if (!dv_zp_r[DV_N])                               zq = '0;
    else if (dv_ov2_r[DV_N] || dv_q2_r[DV_N] > ONE_Q) zq = ONE_Q;
    else                                              zq = dv_q2_r[DV_N];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_prod_r <= dq * zq;
      t_dq_r   <= dq;
      t_act_r  <= dv_act_r[DV_N];
    end
  end

  logic [T_W-1:0]    tz;
  logic [Q_W-1:0]    spec_nxt;
  logic [Q_W-1:0]    e_spec_r;
  logic [PROD_W-1:0] e_dprod_r;
  logic              e_act_r;

  always_comb begin
    tz = t_prod_r[FRAC_BITS-1 +: T_W];
    if (tz > T_W'(THIRD_Q)) begin
      if (tz - T_W'(THIRD_Q) > T_W'(ONE_Q)) spec_nxt = ONE_Q;
      else spec_nxt = Q_W'(tz - T_W'(THIRD_Q));
    end else begin
      spec_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_spec_r  <= spec_nxt;
      e_dprod_r <= kd_r * t_dq_r;
      e_act_r   <= t_act_r;
    end
  end

  // power by squaring, one exponent bit per stage
  logic [Q_W-1:0] pw_acc_r  [0:PW_N];
  logic [Q_W-1:0] pw_base_r [0:PW_N];
  logic [Q_W-1:0] pw_dt_r   [0:PW_N];
  logic           pw_act_r  [0:PW_N];
  logic [Q_W-1:0] pw_acc_nxt  [1:PW_N];
  logic [Q_W-1:0] pw_base_nxt [1:PW_N];

  always_comb begin
    logic [PROD_W-1:0] pa, pb;
    for (int k = 0; k < PW_N; k++) begin
      pa = pw_acc_r[k] * pw_base_r[k];
      pb = pw_base_r[k] * pw_base_r[k];
      pw_acc_nxt[k+1]  = shin_r[k] ? pa[FRAC_BITS +: Q_W] : pw_acc_r[k];
      pw_base_nxt[k+1] = pb[FRAC_BITS +: Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw_acc_r[0]  <= ONE_Q;
      pw_base_r[0] <= e_spec_r;
      pw_dt_r[0]   <= e_dprod_r[FRAC_BITS +: Q_W];
      pw_act_r[0]  <= e_act_r;
      for (int k = 1; k <= PW_N; k++) begin
        pw_acc_r[k]  <= pw_acc_nxt[k];
        pw_base_r[k] <= pw_base_nxt[k];
        pw_dt_r[k]   <= pw_dt_r[k-1];
        pw_act_r[k]  <= pw_act_r[k-1];
      end
    end
  end

  // specular gain, then sum and saturate
  logic [PROD_W-1:0] g_sprod_r;
  logic [Q_W-1:0]    g_dt_r;
  logic              g_act_r;
  logic [SUM_W-1:0]  sum;
  logic [OUT_W-1:0]  intensity_r;

  always_ff @(posedge clk) begin
    if (en) begin
      g_sprod_r <= ks_r * pw_acc_r[PW_N];
      g_dt_r    <= pw_dt_r[PW_N];
      g_act_r   <= pw_act_r[PW_N];
    end
  end

  always_comb begin
    sum = SUM_W'(ka_r);
    if (g_act_r) sum = sum + SUM_W'(g_dt_r) + SUM_W'(g_sprod_r[FRAC_BITS +: Q_W]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      intensity_r <= (sum > SUM_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : sum[OUT_W-1:0];
    end
  end

  assign out_ch.intensity = intensity_r;

endmodule
`default_nettype wire
